### design/gbfu_pkg.sv
// Package for the grouped bit-field unpacker.
// Holds the controller states, decode phases and the command/status structs.
// No dependencies.
package gbfu_pkg;

   localparam int unsigned ByteBits    = 8;
   localparam int unsigned BufBits     = 16;
   localparam int unsigned FillBits    = 5;
   localparam int unsigned CodeBits    = 3;
   localparam int unsigned CountBits   = 9;
   localparam int unsigned WidthBits   = 4;
   localparam int unsigned MaxResults  = 8;
   localparam int unsigned ResultBits  = 4;

   typedef enum logic [0:0] {
      ST_IDLE   = 1'b0,
      ST_DECODE = 1'b1
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_WIDTH = 2'd0,
      PH_COUNT = 2'd1,
      PH_SYMS  = 2'd2
   } phase_type;

   typedef struct packed {
      logic load;
      logic hdr;
      logic sym;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic hdr_ready;
      logic sym_ready;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

### design/gbfu_ctrl.sv
// Controller for the grouped bit-field unpacker.
// Sequences one decode step per cycle unless the output is stalled, and issues commands to the datapath.
// Depends on gbfu_pkg.
module gbfu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gbfu_pkg::dp_status_type status,
   output gbfu_pkg::dp_cmd_type    cmd
);
   import gbfu_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.hdr_ready) begin
               cmd.hdr = 1'b1;
            end else if (status.sym_ready) begin
               if (!status.pend_valid || status.out_free) begin
                  cmd.sym = 1'b1;
               end
            end else if (status.pend_valid) begin
               if (status.out_free) begin
                  cmd.flush = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/gbfu_datapath.sv
// Datapath for the grouped bit-field unpacker.
// Holds the bit buffer, group header state, one pending symbol and the output register.
// Depends on gbfu_pkg.
module gbfu_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_data_byte,
   input  gbfu_pkg::dp_cmd_type    cmd,
   output gbfu_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_symbol,
   output logic [3:0]              rsp_symbol_width,
   output logic                    rsp_group_end,
   output logic                    rsp_last
);
   import gbfu_pkg::*;

   phase_type             phase_ff,  phase_in;
   logic [BufBits-1:0]    buf_ff,    buf_in;
   logic [FillBits-1:0]   fill_ff,   fill_in;
   logic [WidthBits-1:0]  gw_ff,     gw_in;
   logic [CountBits-1:0]  left_ff,   left_in;
   logic [ResultBits-1:0] n_ff,      n_in;

   logic [ByteBits-1:0]   pend_sym_ff,   pend_sym_in;
   logic [WidthBits-1:0]  pend_width_ff, pend_width_in;
   logic                  pend_end_ff,   pend_end_in;
   logic                  pend_valid_ff, pend_valid_in;

   logic [ByteBits-1:0]   out_sym_ff,   out_sym_in;
   logic [WidthBits-1:0]  out_width_ff, out_width_in;
   logic                  out_end_ff,   out_end_in;
   logic                  out_last_ff,  out_last_in;
   logic                  out_valid_ff, out_valid_in;

   logic [WidthBits-1:0]  w_eff;
   logic [FillBits-1:0]   need;
   logic [FillBits-1:0]   sh;
   logic [BufBits-1:0]    tmp;
   logic [ByteBits-1:0]   sym_mask;
   logic [CountBits-1:0]  left_dec;
   logic [FillBits-1:0]   fill_base;
   logic                  more_ok;
   logic                  out_load;

   always_comb begin
      if (gw_ff == '0 || gw_ff > WidthBits'(ByteBits)) begin
         w_eff = WidthBits'(ByteBits);
      end else begin
         w_eff = gw_ff;
      end
      case (phase_ff)
         PH_COUNT: need = FillBits'(ByteBits);
         PH_SYMS:  need = FillBits'(w_eff);
         default:  need = FillBits'(CodeBits);
      endcase
      sh       = fill_ff - need;
      tmp      = buf_ff >> sh;
      sym_mask = ~(8'hFF << w_eff);
      left_dec = left_ff - CountBits'(1);
      more_ok  = (n_ff < ResultBits'(MaxResults));

      status.hdr_ready  = more_ok && (phase_ff != PH_SYMS) && (fill_ff >= need);
      status.sym_ready  = more_ok && (phase_ff == PH_SYMS) && (fill_ff >= need);
      status.pend_valid = pend_valid_ff;
      status.out_free   = !out_valid_ff || !rsp_stall;

      fill_base = (fill_ff > FillBits'(ByteBits)) ? FillBits'(ByteBits) : fill_ff;
   end

   always_comb begin
      phase_in      = phase_ff;
      buf_in        = buf_ff;
      fill_in       = fill_ff;
      gw_in         = gw_ff;
      left_in       = left_ff;
      n_in          = n_ff;
      pend_sym_in   = pend_sym_ff;
      pend_width_in = pend_width_ff;
      pend_end_in   = pend_end_ff;
      pend_valid_in = pend_valid_ff;

      if (cmd.load) begin
         buf_in  = {buf_ff[BufBits-ByteBits-1:0], req_data_byte};
         fill_in = fill_base + FillBits'(ByteBits);
         n_in    = '0;
      end else if (cmd.hdr) begin
         fill_in = sh;
         if (phase_ff == PH_COUNT) begin
            left_in  = (tmp[7:0] == '0) ? CountBits'(256) : {1'b0, tmp[7:0]};
            phase_in = PH_SYMS;
         end else begin
            gw_in    = (tmp[2:0] == '0) ? WidthBits'(ByteBits) : {1'b0, tmp[2:0]};
            phase_in = PH_COUNT;
         end
      end else if (cmd.sym) begin
         fill_in       = sh;
         gw_in         = w_eff;
         left_in       = left_dec;
         n_in          = n_ff + ResultBits'(1);
         pend_sym_in   = tmp[7:0] & sym_mask;
         pend_width_in = w_eff;
         pend_end_in   = (left_dec == '0);
         pend_valid_in = 1'b1;
         if (left_dec == '0) begin
            phase_in = PH_WIDTH;
         end
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_load     = (cmd.sym && pend_valid_ff) || cmd.flush;
      out_sym_in   = out_sym_ff;
      out_width_in = out_width_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (out_load) begin
         out_sym_in   = pend_sym_ff;
         out_width_in = pend_width_ff;
         out_end_in   = pend_end_ff;
         out_last_in  = cmd.flush;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WIDTH;
         buf_ff        <= '0;
         fill_ff       <= '0;
         gw_ff         <= '0;
         left_ff       <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         buf_ff        <= buf_in;
         fill_ff       <= fill_in;
         gw_ff         <= gw_in;
         left_ff       <= left_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_sym_ff   <= pend_sym_in;
      pend_width_ff <= pend_width_in;
      pend_end_ff   <= pend_end_in;
      out_sym_ff    <= out_sym_in;
      out_width_ff  <= out_width_in;
      out_end_ff    <= out_end_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_symbol       = out_sym_ff;
   assign rsp_symbol_width = out_width_ff;
   assign rsp_group_end    = out_end_ff;
   assign rsp_last         = out_last_ff;

endmodule

### design/grouped_bit_field_unpacker_top.sv
// Grouped bit-field unpacker: byte stream in, variable-width symbols out.
// Per byte: a load step, one step per header field or symbol decoded, then a closing step
// that flushes the pending symbol as the last one or returns to idle; at most 8 symbols per byte.
// Each symbol is held as pending and is registered to the output by the next symbol step
// or by the flush; decode takes one field per cycle, but an output stall holds those steps.
// Synchronous reset clears the bit buffer, group state and all valid flags.
module grouped_bit_field_unpacker_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_symbol,
   output logic [3:0] rsp_symbol_width,
   output logic       rsp_group_end,
   output logic       rsp_last
);
   import gbfu_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   gbfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gbfu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol       (rsp_symbol),
      .rsp_symbol_width (rsp_symbol_width),
      .rsp_group_end    (rsp_group_end),
      .rsp_last         (rsp_last)
   );

endmodule

### verif/gbfu_symbol_checker.sv
// Checker for the grouped bit-field unpacker: watches both channels, predicts
// the symbols each byte transfer yields and compares them in order.
// Depends on gbfu_pkg.
module gbfu_symbol_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_symbol,
   input  logic [3:0]  rsp_symbol_width,
   input  logic        rsp_group_end,
   input  logic        rsp_last,
   output int unsigned mismatch_count,
   output int unsigned symbols_outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   import gbfu_pkg::*;

   typedef struct packed {
      logic [7:0] symbol;
      logic [3:0] width;
      logic       group_end;
      logic       last;
   } unpacked_symbol_type;

   unpacked_symbol_type expected_symbols[$];
   unpacked_symbol_type want;

   logic [15:0] held_bits;
   int unsigned held_count;
   phase_type   cur_phase;
   logic [3:0]  cur_width;
   logic [8:0]  symbols_due;

   task automatic report_mismatch(input string what, input int unsigned exp_val,
                                  input int unsigned got_val);
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, exp_val, got_val);
      mismatch_count++;
   endtask

   function automatic logic [7:0] take_bits(input int unsigned n);
      int unsigned rest;
      logic [15:0] value;
      rest = held_count - n;
      value = (held_bits >> rest) & ((16'd1 << n) - 16'd1);
      held_count = rest;
      held_bits = held_bits & ((16'd1 << rest) - 16'd1);
      return value[7:0];
   endfunction

   function automatic void unpack_byte(input logic [7:0] data_byte);
      int unsigned produced;
      bit busy;
      bit have_held;
      logic [7:0] field;
      logic [3:0] w;
      unpacked_symbol_type held_sym;
      produced = 0;
      busy = 1'b1;
      have_held = 1'b0;
      held_sym = '0;
      if (held_count > 8) held_count = 8;
      held_bits = {held_bits[7:0], data_byte};
      held_count = held_count + 8;
      while (busy && produced < MaxResults) begin
         case (cur_phase)
            PH_COUNT: begin
               if (held_count >= 8) begin
                  field = take_bits(8);
                  symbols_due = (field == 8'd0) ? 9'd256 : {1'b0, field};
                  cur_phase = PH_SYMS;
               end else begin
                  busy = 1'b0;
               end
            end
            PH_SYMS: begin
               w = cur_width;
               if (w < 4'd1 || w > 4'd8) begin
                  w = 4'd8;
                  cur_width = 4'd8;
               end
               if (held_count >= w) begin
                  field = take_bits(w);
                  symbols_due = symbols_due - 9'd1;
                  if (have_held) expected_symbols.push_back(held_sym);
                  held_sym = '{symbol: field, width: w, group_end: (symbols_due == 9'd0),
                               last: 1'b0};
                  have_held = 1'b1;
                  if (symbols_due == 9'd0) cur_phase = PH_WIDTH;
                  produced++;
               end else begin
                  busy = 1'b0;
               end
            end
            default: begin
               if (held_count >= 3) begin
                  field = take_bits(3);
                  cur_width = (field[2:0] == 3'd0) ? 4'd8 : {1'b0, field[2:0]};
                  cur_phase = PH_COUNT;
               end else begin
                  cur_phase = PH_WIDTH;
                  busy = 1'b0;
               end
            end
         endcase
      end
      if (have_held) begin
         held_sym.last = 1'b1;
         expected_symbols.push_back(held_sym);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_bits = '0;
         held_count = 0;
         cur_phase = PH_WIDTH;
         cur_width = '0;
         symbols_due = '0;
         expected_symbols.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && !req_stall) unpack_byte(req_data_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_symbols.size() == 0) begin
               report_mismatch("symbol with none expected", 0, rsp_symbol);
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_symbol !== want.symbol)
                  report_mismatch("symbol", want.symbol, rsp_symbol);
               if (rsp_symbol_width !== want.width)
                  report_mismatch("symbol_width", want.width, rsp_symbol_width);
               if (rsp_group_end !== want.group_end)
                  report_mismatch("group_end", want.group_end, rsp_group_end);
               if (rsp_last !== want.last)
                  report_mismatch("last", want.last, rsp_last);
            end
         end
      end
      symbols_outstanding <= expected_symbols.size();
   end

endmodule

### verif/tb_grouped_bit_field_unpacker_top.sv
// Testbench top for the grouped bit-field unpacker: builds a packed group stream,
// sends it byte by byte under varying idle and stall and gives the verdict.
// Depends on gbfu_pkg, grouped_bit_field_unpacker_top and gbfu_symbol_checker.
module tb_grouped_bit_field_unpacker_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomBytes = 300;
   localparam int unsigned PlannedBytes = 320;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_symbol;
   logic [3:0] rsp_symbol_width;
   logic       rsp_group_end;
   logic       rsp_last;

   int unsigned mismatch_count;
   int unsigned symbols_outstanding;
   int unsigned bytes_sent = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          stream_bits[$];

   grouped_bit_field_unpacker_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol       (rsp_symbol),
      .rsp_symbol_width (rsp_symbol_width),
      .rsp_group_end    (rsp_group_end),
      .rsp_last         (rsp_last)
   );

   gbfu_symbol_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_symbol          (rsp_symbol),
      .rsp_symbol_width    (rsp_symbol_width),
      .rsp_group_end       (rsp_group_end),
      .rsp_last            (rsp_last),
      .mismatch_count      (mismatch_count),
      .symbols_outstanding (symbols_outstanding)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic send_byte(input logic [7:0] data_byte);
      int unsigned pressure_phase;
      pressure_phase = bytes_sent * 4 / PlannedBytes;
      case (pressure_phase)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 53; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 53; end
         default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data_byte;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic put_bits(input logic [7:0] value, input int unsigned nbits);
      for (int i = int'(nbits) - 1; i >= 0; i--) stream_bits.push_back(value[i]);
   endtask

   task automatic flush_stream();
      logic [7:0] packed_byte;
      while (stream_bits.size() >= 8) begin
         for (int i = 7; i >= 0; i--) packed_byte[i] = stream_bits.pop_front();
         send_byte(packed_byte);
      end
   endtask

   task automatic put_group(input logic [7:0] width_code, input logic [7:0] count_code);
      int unsigned w;
      int unsigned count;
      w = (width_code[2:0] == 3'd0) ? 8 : width_code[2:0];
      count = (count_code == 8'd0) ? 256 : count_code;
      put_bits(width_code, 3);
      put_bits(count_code, 8);
      for (int unsigned i = 0; i < count; i++)
         put_bits(8'($urandom_range(0, (1 << w) - 1)), w);
   endtask

   initial begin
      int unsigned pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // header-only leading byte, then eight 1-bit symbols per byte
      put_bits(8'd1, 3); put_bits(8'd2, 8); put_bits(8'b10, 2);
      put_bits(8'd1, 3); put_bits(8'd16, 8); put_bits(8'hFF, 8); put_bits(8'h00, 8);
      // width code zero means 8 bits
      put_bits(8'd0, 3); put_bits(8'd2, 8); put_bits(8'hFF, 8); put_bits(8'h00, 8);
      put_bits(8'd7, 3); put_bits(8'd1, 8); put_bits(8'h7F, 7);
      put_bits(8'd3, 3); put_bits(8'd3, 8);
      put_bits(8'd0, 3); put_bits(8'd7, 3); put_bits(8'd5, 3);
      put_bits(8'd5, 3); put_bits(8'd4, 8);
      put_bits(8'd0, 5); put_bits(8'd31, 5); put_bits(8'd21, 5); put_bits(8'd10, 5);
      flush_stream();

      while (bytes_sent < RandomBytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            put_bits(8'($urandom), $urandom_range(1, 8));
         end else if (pick < 10) begin
            put_group(8'($urandom_range(1, 2)), pick[0] ? 8'd0 : 8'd255);
         end else if (pick < 15) begin
            put_group(8'($urandom_range(0, 7)), 8'($urandom_range(13, 40)));
         end else begin
            put_group(8'($urandom_range(0, 7)), 8'($urandom_range(1, 12)));
         end
         flush_stream();
      end
      while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'b0);
      flush_stream();
      req_valid <= 1'b0;

      stall_pct = 0;
      do @(negedge clock); while (symbols_outstanding != 0);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### grouped_bit_field_unpacker_top.f
design/gbfu_pkg.sv
design/gbfu_ctrl.sv
design/gbfu_datapath.sv
design/grouped_bit_field_unpacker_top.sv
verif/gbfu_symbol_checker.sv
verif/tb_grouped_bit_field_unpacker_top.sv
